/* rtl/core/rde_pkg.sv */
// ----------------------------------------------------------------------------
// rde_pkg
// Shared widths, register indexes, status types and helpers for the radix
// digit extractor.
// ----------------------------------------------------------------------------
package rde_pkg;

   localparam int VALUE_BITS     = 63;
   localparam int DIGIT_BITS     = 8;
   localparam int RADIX_BITS     = DIGIT_BITS + 1;
   localparam int MAX_DIGITS     = VALUE_BITS;
   localparam int COUNT_BITS     = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_BITS      = $clog2(MAX_DIGITS);
   localparam int STEP_BITS      = $clog2(VALUE_BITS);
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [RADIX_BITS-1:0] DEFAULT_RADIX = RADIX_BITS'(10);
   localparam logic [RADIX_BITS-1:0] MIN_RADIX     = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] MAX_RADIX     = RADIX_BITS'(1 << DIGIT_BITS);

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_RADIX      = CSR_INDEX_BITS'(0);
   localparam csr_index_type CSR_HIGH_FIRST = CSR_INDEX_BITS'(1);

   typedef struct packed {
      logic busy;
      logic done;
      logic quot_zero;
   } div_status_type;

   // bases below two act as two, bases above the digit range are clipped
   function automatic logic [RADIX_BITS-1:0] eff_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      res = r;
      if (r < MIN_RADIX) begin
         res = MIN_RADIX;
      end else if (r > MAX_RADIX) begin
         res = MAX_RADIX;
      end
      return res;
   endfunction

endpackage

/* rtl/core/rde_divider.sv */
// ----------------------------------------------------------------------------
// rde_divider
// Restoring divider, one quotient bit per cycle. Divides the value by the
// base and holds quotient and remainder after the done pulse.
// ----------------------------------------------------------------------------
module rde_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rde_pkg::VALUE_BITS-1:0]    dividend,
   input  logic [rde_pkg::RADIX_BITS-1:0]    divisor,
   output logic [rde_pkg::VALUE_BITS-1:0]    quotient,
   output logic [rde_pkg::RADIX_BITS-1:0]    remainder,
   output rde_pkg::div_status_type           status
);
   import rde_pkg::*;

   logic [VALUE_BITS-1:0] work_ff, work_in;
   logic [RADIX_BITS-1:0] rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RADIX_BITS:0]   shifted;
   logic [RADIX_BITS:0]   diff;
   logic                  fits;

   // partial remainder with the next dividend bit brought down
   assign shifted = {rem_ff, work_ff[VALUE_BITS-1]};
   assign fits    = shifted >= {1'b0, divisor};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? diff[RADIX_BITS-1:0] : shifted[RADIX_BITS-1:0];
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient         = work_ff;
   assign remainder        = rem_ff;
   assign status.busy      = busy_ff;
   assign status.done      = done_ff;
   assign status.quot_zero = (work_ff == '0);

endmodule

/* rtl/core/rde_digit_store.sv */
// ----------------------------------------------------------------------------
// rde_digit_store
// Digit memory, one write port and one registered read port. Holds the
// digits of a value until they are read back most significant first.
// ----------------------------------------------------------------------------
module rde_digit_store (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [rde_pkg::ADDR_BITS-1:0]    wr_addr,
   input  logic [rde_pkg::DIGIT_BITS-1:0]   wr_data,
   input  logic                             rd_en,
   input  logic [rde_pkg::ADDR_BITS-1:0]    rd_addr,
   output logic [rde_pkg::DIGIT_BITS-1:0]   rd_data
);
   import rde_pkg::*;

   logic [DIGIT_BITS-1:0] mem [MAX_DIGITS];
   logic [DIGIT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/radix_digit_extractor.sv */
// ----------------------------------------------------------------------------
// radix_digit_extractor
// Splits a non-negative binary value into its digits in a configured base.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one 63-bit value per request, taken when req_valid is high
//    and req_stall is low. req_stall is high while a value is being worked on.
//  - rsp_ channel: one result per digit, rsp_last_digit marks the end of the
//    run. A zero value gives a single digit 0.
//  - csr_ channel: index 0 is the base (2..256, reset 10), index 1 selects the
//    order (1 = most significant first, reset). csr_ready is always high;
//    write only while no request is in progress.
//  - each digit costs one pass of the shared bit-serial divider, which is then
//    restarted for the next digit. Least significant first puts each digit
//    into the output register as it restarts the divider. Most significant
//    first writes each digit to the store as it restarts the divider, and
//    reads them all back after the divisions.
//  - the output register lets a new request in while the last digit waits.
//    While a digit waits under rsp_stall the sequencer holds its next digit.
//  - reset (synchronous) empties the output register, stops the divider and
//    restores the register defaults; the digit store is not cleared.
// ----------------------------------------------------------------------------
module radix_digit_extractor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rde_pkg::VALUE_BITS-1:0]     req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rde_pkg::DIGIT_BITS-1:0]     rsp_digit,
   output logic                               rsp_last_digit,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  rde_pkg::csr_index_type             csr_index,
   input  logic [rde_pkg::RADIX_BITS-1:0]     csr_data
);
   import rde_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_DIV     = 5'b00010,
      ST_LOW_PUT = 5'b00100,
      ST_RD      = 5'b01000,
      ST_PUT     = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic                  high_first_ff, high_first_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [ADDR_BITS-1:0]  rd_idx_ff, rd_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_BITS-1:0] rsp_digit_ff, rsp_digit_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  req_take;
   logic                  out_free;
   logic                  out_load;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [RADIX_BITS-1:0] div_remainder;
   div_status_type        div_stat;
   logic                  st_wr;
   logic                  st_rd;
   logic [DIGIT_BITS-1:0] st_rd_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   rde_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (eff_radix(radix_ff)),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_stat)
   );

   rde_digit_store u_store (
      .clock   (clock),
      .wr_en   (st_wr),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data (div_remainder[DIGIT_BITS-1:0]),
      .rd_en   (st_rd),
      .rd_addr (rd_idx_ff),
      .rd_data (st_rd_data)
   );

   // csr registers
   always_comb begin
      radix_in      = radix_ff;
      high_first_in = high_first_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RADIX:      radix_in      = csr_data;
            CSR_HIGH_FIRST: high_first_in = csr_data[0];
            default:        ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      st_wr        = 1'b0;
      st_rd        = 1'b0;
      out_load     = 1'b0;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               div_start    = 1'b1;
               div_dividend = req_value;
               count_in     = '0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (high_first_ff) begin
                  st_wr    = 1'b1;
                  count_in = count_ff + COUNT_BITS'(1);
                  if (div_stat.quot_zero) begin
                     rd_idx_in = count_ff[ADDR_BITS-1:0];
                     state_in  = ST_RD;
                  end else begin
                     div_start = 1'b1;
                  end
               end else begin
                  state_in = ST_LOW_PUT;
               end
            end
         end
         ST_LOW_PUT: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_digit_in = div_remainder[DIGIT_BITS-1:0];
               rsp_last_in  = div_stat.quot_zero;
               count_in     = count_ff + COUNT_BITS'(1);
               if (div_stat.quot_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_RD: begin
            st_rd    = 1'b1;
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_digit_in = st_rd_data;
               rsp_last_in  = (rd_idx_ff == '0);
               if (rd_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - ADDR_BITS'(1);
                  state_in  = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
      rd_idx_ff    <= rd_idx_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         radix_ff      <= DEFAULT_RADIX;
         high_first_ff <= 1'b1;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radix_ff      <= radix_in;
         high_first_ff <= high_first_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit      = rsp_digit_ff;
   assign rsp_last_digit = rsp_last_ff;

   // the divider only finishes a pass that the sequencer is waiting on
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   // read-back never overlaps a running division
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD || state_ff == ST_PUT) |-> !div_stat.busy)
      else $error("divider busy during read-back");

   // digit count stays within the store
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_DIGITS))
      else $error("digit count beyond store depth");

   // the last digit of a run returns the sequencer to idle
   assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_last_in) |=> state_ff == ST_IDLE)
      else $error("sequencer not idle after last digit");

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !out_load)
      else $error("result loaded over a stalled one");

endmodule
